[hdl/poly_sine_voice_bank_top_macros.svh]
// assertion macros used by the port-level checker file
`ifndef POLY_SINE_VOICE_BANK_TOP_MACROS_SVH
`define POLY_SINE_VOICE_BANK_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PSVB_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("psvb check failed");

// next-cycle implication, disabled while reset is low
`define PSVB_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("psvb check failed");

`endif

[hdl/psvb_pkg.sv]
// shared types, codes and constant tables of the sine voice bank
package psvb_pkg;

	localparam int NUM_VOICES_DEF      = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SAMPLE_BITS_DEF     = 24;

	// signed sine times gain product
	localparam int PROD_W = 32;

	// note 45 is 110 Hz
	localparam logic [6:0] RESET_NOTE = 7'd45;

	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic clear;
	} cell_cmd_t;

	typedef logic [31:0] inc_table_t [128];
	typedef logic [15:0] gain_table_t [128];

	// increments of notes 60..71 scaled by 2^40 / 44100
	localparam logic [63:0] OCT_INC [12] = '{
		64'd6522910457,  64'd6910782897,  64'd7321719433,  64'd7757091526,
		64'd8218352192,  64'd8707040844,  64'd9224788436,  64'd9773322900,
		64'd10354474922, 64'd10970184041, 64'd11622505130, 64'd12313615249
	};

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bval;
		logic [63:0] xv;
		res  = '0;
		bval = 64'd1 << 62;
		xv   = x;
		while (bval > xv) bval = bval >> 2;
		while (bval != 0) begin
			if (xv >= res + bval) begin
				xv  = xv - (res + bval);
				res = (res >> 1) + bval;
			end else begin
				res = res >> 1;
			end
			bval = bval >> 2;
		end
		return res;
	endfunction

	function automatic inc_table_t build_inc_table(input int phase_bits);
		inc_table_t tab;
		int o;
		int k;
		int s;
		logic [63:0] v;
		for (int n = 0; n < 128; n++) begin
			o = n / 12;
			k = n % 12;
			s = 45 - o - phase_bits;
			v = (OCT_INC[k] + (64'd1 << (s - 1))) >> s;
			tab[n] = v[31:0];
		end
		return tab;
	endfunction

	// fourth root of velocity / 127 in q1.15
	function automatic gain_table_t build_gain_table();
		gain_table_t tab;
		logic [63:0] x;
		logic [63:0] g;
		for (int n = 0; n < 128; n++) begin
			x = (64'(n) << 56) / 64'd127;
			x = x << 4;
			g = isqrt64(isqrt64(x));
			tab[n] = (g > 64'd32767) ? 16'd32767 : g[15:0];
		end
		return tab;
	endfunction

endpackage

[hdl/psvb_cell.sv]
// one voice slot of the rotating voice ring
module psvb_cell #(
	parameter int PHASE_BITS = psvb_pkg::PHASE_BITS_DEF,
	parameter logic [PHASE_BITS-1:0] RESET_INC = '0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psvb_pkg::cell_cmd_t      cmd,
	input  logic [6:0]               set_note,
	input  logic [PHASE_BITS-1:0]    set_inc,
	input  logic [15:0]              set_gain,
	input  logic [6:0]               nbr_note,
	input  logic [PHASE_BITS-1:0]    nbr_phase,
	input  logic [PHASE_BITS-1:0]    nbr_inc,
	input  logic [15:0]              nbr_gain,
	output logic [6:0]               note,
	output logic [PHASE_BITS-1:0]    phase,
	output logic [PHASE_BITS-1:0]    inc,
	output logic [15:0]              gain
);

	logic [6:0]            note_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic [15:0]           gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q  <= '0;
			phase_q <= '0;
			inc_q   <= RESET_INC;
			gain_q  <= '0;
		end else if (cmd.shift) begin
			note_q  <= nbr_note;
			phase_q <= nbr_phase;
			inc_q   <= nbr_inc;
			gain_q  <= nbr_gain;
		end else if (cmd.load) begin
			note_q <= set_note;
			inc_q  <= set_inc;
			gain_q <= set_gain;
		end else if (cmd.clear && note_q == set_note) begin
			// phase keeps running position on release
			note_q <= '0;
			inc_q  <= '0;
			gain_q <= '0;
		end
	end

	assign note  = note_q;
	assign phase = phase_q;
	assign inc   = inc_q;
	assign gain  = gain_q;

endmodule

[hdl/psvb_sine.sv]
// pipelined quintic sine and gain multiply for the voice at the ring head
module psvb_sine #(
	parameter int TABLE_BITS = psvb_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              issue,
	input  logic [TABLE_BITS-1:0]             idx,
	input  logic [15:0]                       gain,
	output logic                              prod_valid,
	output logic signed [psvb_pkg::PROD_W-1:0] prod,
	output logic                              busy
);

	localparam int QB  = TABLE_BITS - 2;
	localparam int YSH = 17 - TABLE_BITS;
	localparam logic [QB:0] QUARTER = {1'b1, {QB{1'b0}}};

	logic [QB:0] r_ext;
	logic [QB:0] y;
	logic [15:0] y15;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [15:0] gain_s1, gain_s2, gain_s3, gain_s4, gain_s5;
	logic [15:0] y15_s1, y15_s2, y15_s3, y15_s4;
	logic [15:0] y2_s2, y2_s3;
	logic [15:0] inner_s3;
	logic [15:0] mid_s4;
	logic [14:0] mag_s5;
	logic signed [psvb_pkg::PROD_W-1:0] prod_s6;

	logic [31:0] sq;
	logic [31:0] t3;
	logic [31:0] t4;
	logic [31:0] t5;
	logic [16:0] s17;
	logic [psvb_pkg::PROD_W-2:0] pm;

	// mirror the 2nd and 4th quarters
	always_comb begin
		r_ext = {1'b0, idx[QB-1:0]};
		y     = idx[QB] ? (QUARTER - r_ext) : r_ext;
		y15   = 16'(y) << YSH;
	end

	assign sq  = 32'(y15_s1) * 32'(y15_s1);
	assign t3  = 32'(y2_s2) * 32'd2320;
	assign t4  = 32'(y2_s3) * 32'(inner_s3);
	assign t5  = 32'(y15_s4) * 32'(mid_s4) + 32'd16384;
	assign s17 = t5[31:15];
	assign pm  = (psvb_pkg::PROD_W-1)'(mag_s5) * (psvb_pkg::PROD_W-1)'(gain_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		y15_s1  <= y15;
		neg_s1  <= idx[TABLE_BITS-1];
		gain_s1 <= gain;

		y2_s2   <= sq[30:15];
		y15_s2  <= y15_s1;
		neg_s2  <= neg_s1;
		gain_s2 <= gain_s1;

		inner_s3 <= 16'd21024 - t3[30:15];
		y2_s3    <= y2_s2;
		y15_s3   <= y15_s2;
		neg_s3   <= neg_s2;
		gain_s3  <= gain_s2;

		mid_s4  <= 16'd51472 - t4[30:15];
		y15_s4  <= y15_s3;
		neg_s4  <= neg_s3;
		gain_s4 <= gain_s3;

		mag_s5  <= (s17 > 17'd32767) ? 15'h7fff : s17[14:0];
		neg_s5  <= neg_s4;
		gain_s5 <= gain_s4;

		prod_s6 <= neg_s5 ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
	end

	assign prod_valid = v_s6;
	assign prod       = prod_s6;
	assign busy       = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;

endmodule

[hdl/poly_sine_voice_bank_top.sv]
// polyphonic sine voice bank with stereo pass-through
//
// one input stream carries requests: tuser is the mode (sample tick, note on,
// note off), tdata the note, velocity and the left and right input samples.
// a note on or note off leaves ready high and gives no result. a sample tick
// gives one result on the output stream: both input samples plus the sum of
// all voices, saturated to SAMPLE_BITS.
// a tick walks the voice ring past one shared sine and gain pipeline, one
// voice per cycle, then waits for the pipeline to drain; the result shows
// and ready comes back in the same cycle. the single multiplier pipeline
// and the ring length set how long a tick takes.
// ready is low for the whole tick; note requests may be taken while a
// result waits on the output. if the receiver stalls, the result holds
// stable and the next tick waits at its last step until the output is free.
// reset clears all voices, points allocation at slot zero and loads the
// 110 Hz increment into every slot.
module poly_sine_voice_bank_top #(
	parameter int NUM_VOICES      = psvb_pkg::NUM_VOICES_DEF,
	parameter int SINE_TABLE_BITS = psvb_pkg::SINE_TABLE_BITS_DEF,
	parameter int PHASE_BITS      = psvb_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS     = psvb_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W  = ((14 + 2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// note_number, velocity, in_left, in_right
	input  logic [IN_W-1:0]  s_axis_tdata,
	// mode
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// out_left, out_right
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int SLOT_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int PROD_W = psvb_pkg::PROD_W;
	localparam int MIX_W  = PROD_W + SLOT_W;
	localparam int SUM_W  = MIX_W + 3;
	localparam int LSH    = (SAMPLE_BITS >= 31) ? SAMPLE_BITS - 31 : 0;
	localparam int RSH    = (SAMPLE_BITS >= 31) ? 0 : 31 - SAMPLE_BITS;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_VOICES - 1);

	localparam psvb_pkg::inc_table_t  INC_TABLE  = psvb_pkg::build_inc_table(PHASE_BITS);
	localparam psvb_pkg::gain_table_t GAIN_TABLE = psvb_pkg::build_gain_table();
	localparam logic [PHASE_BITS-1:0] RESET_INC =
		PHASE_BITS'(INC_TABLE[psvb_pkg::RESET_NOTE]);

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
		return (x == LAST_SLOT) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [SUM_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[SUM_W-1:SAMPLE_BITS-1];
		all_zero = ~|v[SUM_W-1:SAMPLE_BITS-1];
		if (all_one || all_zero) return v[SAMPLE_BITS-1:0];
		else if (v[SUM_W-1]) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	endfunction

	logic [1:0]                     mode;
	logic [6:0]                     note_in;
	logic [6:0]                     vel_in;
	logic signed [SAMPLE_BITS-1:0]  in_left;
	logic signed [SAMPLE_BITS-1:0]  in_right;

	psvb_pkg::seq_state_t state_q, state_d;
	logic [SLOT_W-1:0] step_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic signed [SAMPLE_BITS-1:0] in_left_q;
	logic signed [SAMPLE_BITS-1:0] in_right_q;
	logic signed [MIX_W-1:0] mix_q;
	logic out_valid_q;
	logic [SAMPLE_BITS-1:0] out_left_q;
	logic [SAMPLE_BITS-1:0] out_right_q;

	logic accept;
	logic is_tick;
	logic is_on;
	logic is_off;
	logic run_shift;
	logic out_load;
	logic slot_busy;
	logic [SLOT_W-1:0] target;

	logic [6:0]            c_note  [NUM_VOICES];
	logic [PHASE_BITS-1:0] c_phase [NUM_VOICES];
	logic [PHASE_BITS-1:0] c_inc   [NUM_VOICES];
	logic [15:0]           c_gain  [NUM_VOICES];
	logic [PHASE_BITS-1:0] wrap_phase;
	logic [PHASE_BITS-1:0] set_inc;
	logic [15:0]           set_gain;

	logic                      prod_valid;
	logic signed [PROD_W-1:0]  prod;
	logic                      pipe_busy;

	logic signed [SUM_W-1:0] scaled;
	logic signed [SUM_W-1:0] sum_left;
	logic signed [SUM_W-1:0] sum_right;

	assign mode     = s_axis_tuser;
	assign note_in  = s_axis_tdata[6:0];
	assign vel_in   = s_axis_tdata[13:7];
	assign in_left  = s_axis_tdata[14 +: SAMPLE_BITS];
	assign in_right = s_axis_tdata[14 + SAMPLE_BITS +: SAMPLE_BITS];

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign is_tick = accept && (mode == psvb_pkg::MODE_TICK);
	assign is_on   = accept && (mode == psvb_pkg::MODE_NOTE_ON);
	assign is_off  = accept && (mode == psvb_pkg::MODE_NOTE_OFF);

	// the ring is in slot order whenever requests are taken
	assign slot_busy = (c_note[next_slot_q] != 7'd0);
	assign target    = slot_busy ? slot_inc(next_slot_q) : next_slot_q;
	assign set_inc   = PHASE_BITS'(INC_TABLE[note_in]);
	assign set_gain  = GAIN_TABLE[vel_in];

	// head voice re-enters at the tail with its phase advanced
	assign wrap_phase = c_phase[0] + c_inc[0];

	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_ring
		localparam int NB = (i + 1) % NUM_VOICES;
		psvb_pkg::cell_cmd_t cmd;
		logic [PHASE_BITS-1:0] nbr_phase;

		assign cmd.shift = run_shift;
		assign cmd.load  = is_on && (target == SLOT_W'(i));
		assign cmd.clear = is_off;

		if (i == NUM_VOICES - 1) begin : g_tail
			assign nbr_phase = wrap_phase;
		end else begin : g_mid
			assign nbr_phase = c_phase[NB];
		end

		psvb_cell #(
			.PHASE_BITS (PHASE_BITS),
			.RESET_INC  (RESET_INC)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.set_note  (note_in),
			.set_inc   (set_inc),
			.set_gain  (set_gain),
			.nbr_note  (c_note[NB]),
			.nbr_phase (nbr_phase),
			.nbr_inc   (c_inc[NB]),
			.nbr_gain  (c_gain[NB]),
			.note      (c_note[i]),
			.phase     (c_phase[i]),
			.inc       (c_inc[i]),
			.gain      (c_gain[i])
		);
	end

	psvb_sine #(
		.TABLE_BITS (SINE_TABLE_BITS)
	) u_sine (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (run_shift),
		.idx        (c_phase[0][PHASE_BITS-1 -: SINE_TABLE_BITS]),
		.gain       (c_gain[0]),
		.prod_valid (prod_valid),
		.prod       (prod),
		.busy       (pipe_busy)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psvb_pkg::ST_IDLE:   if (is_tick) state_d = psvb_pkg::ST_RUN;
			psvb_pkg::ST_RUN:    if (step_q == LAST_SLOT) state_d = psvb_pkg::ST_DRAIN;
			psvb_pkg::ST_DRAIN:  if (!pipe_busy) state_d = psvb_pkg::ST_FINISH;
			psvb_pkg::ST_FINISH: if (out_load) state_d = psvb_pkg::ST_IDLE;
			default:             state_d = psvb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		run_shift     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			psvb_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			psvb_pkg::ST_RUN:    run_shift = 1'b1;
			psvb_pkg::ST_DRAIN:  ;
			psvb_pkg::ST_FINISH: out_load = !out_valid_q || m_axis_tready;
			default:             ;
		endcase
	end

	// floor scaling of the q(2+SLOT_W).30 mix (q6.30 at 16 voices) to sample full scale
	always_comb begin
		scaled    = (SUM_W'(mix_q) <<< LSH) >>> RSH;
		sum_left  = scaled + SUM_W'(in_left_q);
		sum_right = scaled + SUM_W'(in_right_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psvb_pkg::ST_IDLE;
			step_q      <= '0;
			next_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_tick) step_q <= '0;
			else if (run_shift) step_q <= step_q + 1'b1;
			if (is_on) next_slot_q <= slot_inc(target);
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			in_left_q  <= in_left;
			in_right_q <= in_right;
			mix_q      <= '0;
		end else if (prod_valid) begin
			mix_q <= mix_q + MIX_W'(prod);
		end
		if (out_load) begin
			out_left_q  <= saturate(sum_left);
			out_right_q <= saturate(sum_right);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_right_q, out_left_q});

endmodule

[hdl/psvb_check.sv]
// port-level checks of the sine voice bank, bound to the top level
`include "poly_sine_voice_bank_top_macros.svh"

module psvb_check #(
	parameter int IN_W  = 64,
	parameter int OUT_W = 48
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic [1:0]       s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a stalled result stays put
	`PSVB_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a tick request closes the input while the voices are walked
	`PSVB_ASSERT_NXT(a_tick_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == psvb_pkg::MODE_TICK, !s_axis_tready)

	// note and unused requests leave the input open
	`PSVB_ASSERT_NXT(a_note_fast, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser != psvb_pkg::MODE_TICK, s_axis_tready)

	// a new result only comes out of tick work
	`PSVB_ASSERT_IMP(a_result_from_tick, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind poly_sine_voice_bank_top psvb_check #(
	.IN_W  (IN_W),
	.OUT_W (OUT_W)
) u_psvb_check (.*);
